>>> src/hslp_pkg.sv
// Package for the linear-probing hash set core.
// Holds slot states, result codes, operation codes and the controller state type.
// No dependencies.
package hslp_pkg;

	typedef enum logic [1:0] {
		ST_EMPTY = 2'd0,
		ST_USED  = 2'd1,
		ST_TOMB  = 2'd2
	} slot_st_t;

	typedef enum logic [1:0] {
		RES_DONE    = 2'd0,
		RES_PRESENT = 2'd1,
		RES_ABSENT  = 2'd2,
		RES_FULL    = 2'd3
	} res_t;

	typedef enum logic [1:0] {
		OP_INSERT   = 2'd0,
		OP_CONTAINS = 2'd1,
		OP_REMOVE   = 2'd2
	} op_t;

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_HOME  = 5'b00100,
		S_PROBE = 5'b01000,
		S_DONE  = 5'b10000
	} fsm_t;

endpackage

>>> src/hslp_home.sv
// Home slot unit: key mod SLOTS.
// A power-of-two table takes the low key bits; any other size folds in one key byte a
// cycle with a reciprocal multiplication and one corrective subtract. No package dependencies.
module hslp_home #(
	parameter int SLOTS    = 16,
	parameter int KEY_BITS = 31
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [KEY_BITS-1:0]        key,
	output logic                       done,
	output logic [$clog2(SLOTS)-1:0]   home
);

	localparam int  IDXW    = $clog2(SLOTS);
	localparam bit  IS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);

	generate
		if (IS_POW2) begin : g_pow2
			logic            done_q;
			logic [IDXW-1:0] home_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					home_q <= IDXW'(key);
				end
			end

			assign done = done_q;
			assign home = home_q;
		end else begin : g_fold
			localparam int            CHUNK   = 8;
			localparam int            NCH     = (KEY_BITS + CHUNK - 1) / CHUNK;
			localparam int            PADW    = NCH * CHUNK;
			localparam int            VW      = IDXW + CHUNK;
			localparam int            CNTW    = $clog2(NCH + 1);
			localparam logic [VW-1:0] SLOTS_V = VW'(SLOTS);
			localparam logic [VW-1:0] RECIP   = VW'((64'd1 << VW) / 64'(SLOTS));

			logic                busy_q;
			logic                done_q;
			logic [CNTW-1:0]     cnt_q;
			logic [PADW-1:0]     sh_q;
			logic [IDXW-1:0]     rem_q;
			logic [VW-1:0]       v;
			logic [2*VW-1:0]     prod;
			logic [2*VW-1:0]     qs;
			logic [VW-1:0]       r_est;
			logic [IDXW-1:0]     rem_nxt;

			// fold in the next key byte: the quotient estimate is low by at most one
			always_comb begin
				v       = {rem_q, sh_q[PADW-1 -: CHUNK]};
				prod    = (2*VW)'(v) * (2*VW)'(RECIP);
				qs      = (2*VW)'(prod[2*VW-1:VW]) * (2*VW)'(SLOTS);
				r_est   = v - qs[VW-1:0];
				rem_nxt = (r_est >= SLOTS_V) ? IDXW'(r_est - SLOTS_V) : r_est[IDXW-1:0];
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					busy_q <= 1'b0;
					done_q <= 1'b0;
					cnt_q  <= '0;
				end else begin
					done_q <= 1'b0;
					if (start) begin
						busy_q <= 1'b1;
						cnt_q  <= CNTW'(NCH);
					end else if (busy_q) begin
						cnt_q <= cnt_q - CNTW'(1);
						if (cnt_q == CNTW'(1)) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end
					end
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					sh_q  <= PADW'(key);
					rem_q <= '0;
				end else if (busy_q) begin
					sh_q  <= sh_q << CHUNK;
					rem_q <= rem_nxt;
				end
			end

			assign done = done_q;
			assign home = rem_q;
		end
	endgenerate

endmodule

>>> src/hslp_table.sv
// Slot table: one synchronous memory of {slot state, key} entries.
// One write port and one read port with registered read data.
// No package dependencies.
module hslp_table #(
	parameter int SLOTS    = 16,
	parameter int KEY_BITS = 31
) (
	input  logic                       clk,
	input  logic                       rd_en,
	input  logic [$clog2(SLOTS)-1:0]   rd_addr,
	output logic [KEY_BITS+1:0]        rd_data,
	input  logic                       wr_en,
	input  logic [$clog2(SLOTS)-1:0]   wr_addr,
	input  logic [KEY_BITS+1:0]        wr_data
);

	logic [KEY_BITS+1:0] mem [SLOTS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> src/hash_set_linear_probing_core.sv
// Open-addressing hash set with linear probing over a slot memory.
// Input channel (in_valid / in_stall) carries opcode and key: insert, contains, remove.
// Output channel (out_valid / out_stall) carries one item per input: ok and status.
// One operation is worked at a time. After acceptance the home unit forms the home
// slot, then the slot memory is read one slot per cycle from the home slot, wrapping,
// with each slot checked in the cycle after its read. When a check ends the probe,
// the result is staged and the operation waits in S_DONE for the output register,
// then returns to idle, where the next item can be accepted.
// The single read port of the slot memory sets the probe rate.
// Unused opcode 3 returns not present without touching the table.
// At reset the block sweeps the memory to mark every slot empty, one slot per
// cycle, with in_stall high, then accepts items.
// The result sits in an output register; a new item is accepted while it waits.
// If the receiver stalls, a finished operation holds until the register frees.
module hash_set_linear_probing_core
	import hslp_pkg::*;
#(
	parameter int SLOTS    = 16,
	parameter int KEY_BITS = 31
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          opcode,
	input  logic [KEY_BITS-1:0] key,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                ok,
	output logic [1:0]          status
);

	localparam int IDXW = $clog2(SLOTS);
	localparam int CW   = $clog2(SLOTS + 1);

	fsm_t                state_q;
	logic [IDXW-1:0]     clr_q;
	logic [1:0]          op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [IDXW-1:0]     slot_q;
	logic [CW-1:0]       cnt_q;
	logic                chk_v_s1;
	logic [IDXW-1:0]     chk_slot_s1;
	logic                chk_last_s1;
	logic                have_tomb_q;
	logic [IDXW-1:0]     tomb_q;
	logic                res_ok_q;
	res_t                res_st_q;
	logic                out_valid_q;
	logic                ok_q;
	res_t                status_q;

	logic                accept;
	logic                home_done;
	logic [IDXW-1:0]     home;
	logic                issue;
	logic                rd_en;
	logic [KEY_BITS+1:0] rd_data;
	logic                wr_en;
	logic [IDXW-1:0]     wr_addr;
	logic [KEY_BITS+1:0] wr_data;
	slot_st_t            rd_st;
	logic                hit;
	logic                is_empty;
	logic                is_tomb;
	logic                dec;
	logic                d_ok;
	res_t                d_st;
	logic                d_wr;
	logic [IDXW-1:0]     d_addr;
	slot_st_t            d_wr_st;
	logic                out_free;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign issue    = (state_q == S_PROBE) && (cnt_q != CW'(SLOTS));
	assign rd_en    = issue;

	hslp_home #(
		.SLOTS    (SLOTS),
		.KEY_BITS (KEY_BITS)
	) u_home (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.key    (key),
		.done   (home_done),
		.home   (home)
	);

	hslp_table #(
		.SLOTS    (SLOTS),
		.KEY_BITS (KEY_BITS)
	) u_table (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (slot_q),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	assign rd_st    = slot_st_t'(rd_data[KEY_BITS+1:KEY_BITS]);
	assign hit      = (rd_st == ST_USED) && (rd_data[KEY_BITS-1:0] == key_q);
	assign is_empty = (rd_st == ST_EMPTY);
	assign is_tomb  = (rd_st == ST_TOMB);

	// check the slot read last cycle
	always_comb begin
		dec     = 1'b0;
		d_ok    = 1'b0;
		d_st    = RES_ABSENT;
		d_wr    = 1'b0;
		d_addr  = chk_slot_s1;
		d_wr_st = ST_USED;
		if (chk_v_s1 && state_q == S_PROBE) begin
			if (op_q == OP_INSERT) begin
				if (hit) begin
					dec  = 1'b1;
					d_st = RES_PRESENT;
				end else if (is_empty || (chk_last_s1 && (have_tomb_q || is_tomb))) begin
					// reuse the first tombstone on the path, else this slot
					dec    = 1'b1;
					d_ok   = 1'b1;
					d_st   = RES_DONE;
					d_wr   = 1'b1;
					d_addr = have_tomb_q ? tomb_q : chk_slot_s1;
				end else if (chk_last_s1) begin
					dec  = 1'b1;
					d_st = RES_FULL;
				end
			end else begin
				if (is_empty) begin
					dec = 1'b1;
				end else if (hit) begin
					dec     = 1'b1;
					d_ok    = 1'b1;
					d_st    = RES_DONE;
					d_wr    = (op_q == OP_REMOVE);
					d_wr_st = ST_TOMB;
				end else if (chk_last_s1) begin
					dec = 1'b1;
				end
			end
		end
	end

	// the write lands before the next item's first read, so no forwarding is needed
	always_comb begin
		if (state_q == S_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_data = {ST_EMPTY, key_q};
		end else begin
			wr_en   = dec && d_wr;
			wr_addr = d_addr;
			wr_data = {d_wr_st, key_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			chk_v_s1    <= 1'b0;
			have_tomb_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			chk_v_s1 <= 1'b0;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + IDXW'(1);
					if (clr_q == IDXW'(SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						case (opcode)
							OP_INSERT, OP_CONTAINS, OP_REMOVE: state_q <= S_HOME;
							default:                           state_q <= S_DONE;
						endcase
					end
				end
				S_HOME: begin
					if (home_done) begin
						cnt_q       <= '0;
						have_tomb_q <= 1'b0;
						state_q     <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (dec) begin
						state_q <= S_DONE;
					end else begin
						if (issue) begin
							cnt_q    <= cnt_q + CW'(1);
							chk_v_s1 <= 1'b1;
						end
						if (chk_v_s1 && is_tomb && !have_tomb_q) begin
							have_tomb_q <= 1'b1;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= opcode;
			key_q    <= key;
			res_ok_q <= 1'b0;
			res_st_q <= RES_ABSENT;
		end
		if (state_q == S_HOME && home_done) begin
			slot_q <= home;
		end
		if (issue && !dec) begin
			slot_q      <= (slot_q == IDXW'(SLOTS - 1)) ? '0 : slot_q + IDXW'(1);
			chk_slot_s1 <= slot_q;
			chk_last_s1 <= (cnt_q == CW'(SLOTS - 1));
		end
		if (chk_v_s1 && is_tomb && !have_tomb_q) begin
			tomb_q <= chk_slot_s1;
		end
		if (dec) begin
			res_ok_q <= d_ok;
			res_st_q <= d_st;
		end
		if (state_q == S_DONE && out_free) begin
			ok_q     <= res_ok_q;
			status_q <= res_st_q;
		end
	end

	assign out_valid = out_valid_q;
	assign ok        = ok_q;
	assign status    = status_q;

endmodule

>>> src/hslp_check.sv
// Port checker for the hash set core, bound to the top level.
// Depends on hslp_pkg for the result codes.
module hslp_check
	import hslp_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       ok,
	input logic [1:0] status
);

	logic       acc;
	logic       del;
	logic [1:0] pend_q;

	assign acc = in_valid && !in_stall;
	assign del = out_valid && !out_stall;

	// count items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (acc && !del) begin
			pend_q <= pend_q + 2'd1;
		end else if (del && !acc) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> in_stall)
		else $error("item accepted while another is in work");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(ok) && $stable(status))
		else $error("stalled result changed");

	a_ok_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (ok == (status == RES_DONE)))
		else $error("ok disagrees with status");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result without an accepted item");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("too many items outstanding");

endmodule

bind hash_set_linear_probing_core hslp_check u_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.ok        (ok),
	.status    (status)
);

>>> test/tb.sv
// Testbench for hash_set_linear_probing_core: insert, contains and remove items
// are checked against a slot-by-slot predictor held in a small scoreboard class.
// Depends on hslp_pkg and the core.
module tb;
	import hslp_pkg::*;

	localparam int SLOTS        = 16;
	localparam int KEY_BITS     = 31;
	localparam int POOL         = 24;
	localparam int RANDOM_ITEMS = 480;
	localparam int QUIET_ITEMS  = 100;
	localparam int MAX_CYCLES   = 200000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic ok;
		res_t status;
	} reply_t;

	class set_scoreboard;
		slot_st_t            slot_state[SLOTS];
		logic [KEY_BITS-1:0] slot_key[SLOTS];
		reply_t              awaited[$];
		int                  errors;

		function new();
			foreach (slot_state[i]) begin
				slot_state[i] = ST_EMPTY;
				slot_key[i] = '0;
			end
			errors = 0;
		endfunction

		// Walk the probe path of k and update the slots the way the core should.
		function reply_t apply_op(logic [1:0] opc, logic [KEY_BITS-1:0] k);
			reply_t r;
			bit have_tomb;
			int tomb;
			int s;
			r.ok = 1'b0;
			r.status = RES_ABSENT;
			have_tomb = 0;
			tomb = 0;
			case (opc)
				OP_INSERT: begin
					for (int i = 0; i < SLOTS; i++) begin
						s = (int'(k % SLOTS) + i) % SLOTS;
						if (slot_state[s] == ST_USED && slot_key[s] == k) begin
							r.status = RES_PRESENT;
							return r;
						end
						if (slot_state[s] == ST_TOMB && !have_tomb) begin
							have_tomb = 1;
							tomb = s;
						end
						if (slot_state[s] == ST_EMPTY) begin
							if (!have_tomb)
								tomb = s;
							slot_state[tomb] = ST_USED;
							slot_key[tomb] = k;
							r.ok = 1'b1;
							r.status = RES_DONE;
							return r;
						end
					end
					if (have_tomb) begin
						slot_state[tomb] = ST_USED;
						slot_key[tomb] = k;
						r.ok = 1'b1;
						r.status = RES_DONE;
					end else begin
						r.status = RES_FULL;
					end
				end
				OP_CONTAINS, OP_REMOVE: begin
					for (int i = 0; i < SLOTS; i++) begin
						s = (int'(k % SLOTS) + i) % SLOTS;
						if (slot_state[s] == ST_EMPTY)
							break;
						if (slot_state[s] == ST_USED && slot_key[s] == k) begin
							if (opc == OP_REMOVE)
								slot_state[s] = ST_TOMB;
							r.ok = 1'b1;
							r.status = RES_DONE;
							return r;
						end
					end
				end
				default: ;
			endcase
			return r;
		endfunction

		function void note_request(logic [1:0] opc, logic [KEY_BITS-1:0] k);
			awaited.push_back(apply_op(opc, k));
		endfunction

		function void check_reply(logic got_ok, logic [1:0] got_status);
			reply_t want;
			if (awaited.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("result with nothing awaited: ok=%0d status=%0d", got_ok, got_status);
				return;
			end
			want = awaited.pop_front();
			if (got_ok !== want.ok || got_status !== want.status) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: ok exp %0d got %0d, status exp %0d got %0d",
						want.ok, got_ok, want.status, got_status);
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [1:0]          opcode;
	logic [KEY_BITS-1:0] key;
	logic                out_valid;
	logic                out_stall;
	logic                ok;
	logic [1:0]          status;

	set_scoreboard       sb;
	bit                  quiet;
	int                  stall_left;
	int                  cycles;
	logic [KEY_BITS-1:0] key_pool[POOL];

	hash_set_linear_probing_core #(
		.SLOTS(SLOTS),
		.KEY_BITS(KEY_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.key(key),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.ok(ok),
		.status(status)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > MAX_CYCLES) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_request(opcode, key);
		if (arst_n && out_valid && !out_stall)
			sb.check_reply(ok, status);
	end

	// Receiver: stall in short bursts, none once the run goes quiet.
	initial begin
		out_stall <= 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (!quiet && stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				stall_left = 0;
				if (!quiet && $urandom_range(0, 4) == 0)
					stall_left = $urandom_range(1, 5);
			end
		end
	end

	task automatic send_op(input logic [1:0] opc, input logic [KEY_BITS-1:0] k);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= opc;
		key <= k;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Hold the sender until every awaited result is back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic logic [1:0] pick_op(bit filling);
		int p;
		p = $urandom_range(0, 99);
		if (filling)
			return (p < 60) ? OP_INSERT : (p < 80) ? OP_CONTAINS : (p < 95) ? OP_REMOVE : OP_UNUSED;
		return (p < 25) ? OP_INSERT : (p < 55) ? OP_CONTAINS : (p < 95) ? OP_REMOVE : OP_UNUSED;
	endfunction

	function automatic logic [KEY_BITS-1:0] pick_key();
		logic [31:0] r;
		r = $urandom();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5, 6: return key_pool[$urandom_range(0, POOL - 1)];
			7, 8: return r[KEY_BITS-1:0];
			default: return r[0] ? '1 : '0;
		endcase
	endfunction

	initial begin
		logic [31:0] r;
		sb = new();
		quiet = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		opcode <= OP_INSERT;
		key <= '0;
		// Half the pool crowds four home slots to build long probe chains.
		foreach (key_pool[i]) begin
			r = $urandom();
			key_pool[i] = r[KEY_BITS-1:0];
			if (i % 2 == 0)
				key_pool[i][3:0] = 4'($urandom_range(0, 3));
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_op(OP_INSERT, '0);
		send_op(OP_INSERT, '1);
		send_op(OP_INSERT, '0);
		send_op(OP_CONTAINS, '1);
		send_op(OP_CONTAINS, KEY_BITS'(16));
		send_op(OP_REMOVE, '1);
		send_op(OP_REMOVE, '1);
		send_op(OP_UNUSED, '0);
		send_op(OP_CONTAINS, KEY_BITS'(31));
		// reuse the tombstone in the top slot
		send_op(OP_INSERT, KEY_BITS'(15));
		// fill slots 1..14 through one collision chain
		for (int j = 1; j <= 14; j++)
			send_op(OP_INSERT, KEY_BITS'(16 * j + 1));
		send_op(OP_INSERT, KEY_BITS'(5));
		send_op(OP_CONTAINS, KEY_BITS'(5));
		send_op(OP_REMOVE, '0);
		// full scan with only a tombstone left: insert lands there after the loop
		send_op(OP_INSERT, {{(KEY_BITS - 4){1'b1}}, 4'h0});
		send_op(OP_UNUSED, '1);
		wait_drained();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS - QUIET_ITEMS)
				quiet = 1;
			if (n == RANDOM_ITEMS / 2)
				wait_drained();
			send_op(pick_op((n / 50) % 2 == 0), pick_key());
		end
		wait_drained();
		repeat (30) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

>>> filelist.f
src/hslp_pkg.sv
src/hslp_home.sv
src/hslp_table.sv
src/hash_set_linear_probing_core.sv
src/hslp_check.sv
test/tb.sv
